[sv/all_pairs_shortest_path_unit_assert.svh]
// Assertion macros shared by the checker of the all pairs shortest path unit
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_ASSERT_SVH

// Clocked assertion, muted while reset is asserted
`define APSP_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define APSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/apsp_pkg.sv]
// Types, constants and helpers of the all pairs shortest path unit
`timescale 1ns / 1ps
package apsp_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int IDX_W        = 3;
  localparam int VCNT_W       = 4;
  localparam int W_W          = 16;
  localparam int DIST_W       = 24;
  localparam int ADDR_W       = 2 * IDX_W;
  localparam int DEPTH        = 1 << ADDR_W;

  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(MAX_VERTICES);
  localparam logic [VCNT_W-1:0] VCNT_LIMIT = VCNT_W'(MAX_VERTICES);

  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};

  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIAG,
    ST_RD_IK,
    ST_WAIT_IK,
    ST_RD_J,
    ST_CMP,
    ST_RD_KK,
    ST_CHK_KK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        src;
    logic [IDX_W-1:0]        dst;
    logic signed [W_W-1:0]   weight;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [DIST_W-1:0] distance;
    logic                     reachable;
    logic                     negative_cycle;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic                     we;
    logic [ADDR_W-1:0]        addr;
    logic signed [DIST_W-1:0] data;
  } ram_wr_t;

  // Add two distances and clamp to the distance range
  function automatic logic signed [DIST_W-1:0] sat_add(
    input logic signed [DIST_W-1:0] a,
    input logic signed [DIST_W-1:0] b
  );
    logic signed [DIST_W:0] s;
    s = {a[DIST_W-1], a} + {b[DIST_W-1], b};
    if (s[DIST_W] != s[DIST_W-1]) begin
      sat_add = s[DIST_W] ? DIST_MIN : DIST_MAX;
    end else begin
      sat_add = s[DIST_W-1:0];
    end
  endfunction

endpackage

[sv/apsp_dist_ram.sv]
// Distance matrix storage: one write port, two registered read ports
`timescale 1ns / 1ps
module apsp_dist_ram (
  input  logic                              clk,
  input  apsp_pkg::ram_wr_t                 wr,
  input  logic [apsp_pkg::ADDR_W-1:0]       rd_a_addr,
  input  logic [apsp_pkg::ADDR_W-1:0]       rd_b_addr,
  output logic signed [apsp_pkg::DIST_W-1:0] rd_a_data,
  output logic signed [apsp_pkg::DIST_W-1:0] rd_b_data
);

  logic signed [apsp_pkg::DIST_W-1:0] mem [apsp_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read returns the old value on a same-address write
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

[sv/all_pairs_shortest_path_unit.sv]
// Top level: Floyd-Warshall all pairs shortest path over a small distance matrix
`timescale 1ns / 1ps
// Edge transaction: taken while idle, busy stays low, next one may follow at once.
// Run transaction with n vertices: the diagonal is zeroed, then for each k the matrix is
//   relaxed by the read/compare/write of the matrix RAM, then all n*n entries are emitted;
//   each strobe comes the cycle after its RAM read.
// Synchronous active-low reset: idle, all entries unreachable, flag clear, count 8.
module all_pairs_shortest_path_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  apsp_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  output apsp_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [apsp_pkg::VCNT_W-1:0]         cfg_data
);

  apsp_pkg::state_t state_r, state_nxt;

  logic [apsp_pkg::IDX_W-1:0]          i_r, i_nxt;
  logic [apsp_pkg::IDX_W-1:0]          j_r, j_nxt;
  logic [apsp_pkg::IDX_W-1:0]          k_r, k_nxt;
  logic signed [apsp_pkg::DIST_W-1:0]  dik_r, dik_nxt;
  logic [apsp_pkg::DEPTH-1:0]          reach_r, reach_nxt;
  logic                                neg_r, neg_nxt;
  logic [apsp_pkg::VCNT_W-1:0]         vcount_r;

  // emission metadata, aligned with the registered RAM read
  logic                                out_valid_r, out_valid_nxt;
  logic [apsp_pkg::IDX_W-1:0]          em_row_r, em_row_nxt;
  logic [apsp_pkg::IDX_W-1:0]          em_col_r, em_col_nxt;
  logic                                em_reach_r, em_reach_nxt;
  logic                                em_last_r, em_last_nxt;
  logic                                em_neg_r, em_neg_nxt;

  // RAM interface
  apsp_pkg::ram_wr_t                   wr;
  logic [apsp_pkg::ADDR_W-1:0]         rd_a_addr, rd_b_addr;
  logic signed [apsp_pkg::DIST_W-1:0]  rd_a_data, rd_b_data;

  // effective vertex count and last index
  logic [apsp_pkg::VCNT_W-1:0]         n_eff;
  logic [apsp_pkg::VCNT_W-1:0]         n_m1_full;
  logic [apsp_pkg::IDX_W-1:0]          n_m1;
  logic                                in_acc;
  logic                                edge_ok;
  logic                                i_end, j_end, k_end;
  logic [apsp_pkg::ADDR_W-1:0]         a_ij, a_ik, a_kj, a_kk;
  logic signed [apsp_pkg::DIST_W-1:0]  sum;

  assign n_eff     = (vcount_r > apsp_pkg::VCNT_LIMIT) ? apsp_pkg::VCNT_LIMIT : vcount_r;
  assign n_m1_full = n_eff - apsp_pkg::VCNT_W'(1);
  assign n_m1      = n_m1_full[apsp_pkg::IDX_W-1:0];
  assign i_end     = (i_r == n_m1);
  assign j_end     = (j_r == n_m1);
  assign k_end     = (k_r == n_m1);

  assign a_ij = {i_r, j_r};
  assign a_ik = {i_r, k_r};
  assign a_kj = {k_r, j_r};
  assign a_kk = {k_r, k_r};

  assign in_acc  = start && !busy;
  assign edge_ok = ({1'b0, in_data.src} < n_eff) && ({1'b0, in_data.dst} < n_eff);

  // in the compare state port A holds d[k][j], port B holds d[i][j]
  assign sum = apsp_pkg::sat_add(dik_r, rd_a_data);

  apsp_dist_ram u_ram (
    .clk       (clk),
    .wr        (wr),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= apsp_pkg::ST_IDLE;
      reach_r     <= '0;
      neg_r       <= 1'b0;
      out_valid_r <= 1'b0;
      vcount_r    <= apsp_pkg::VCNT_RESET;
    end else begin
      state_r     <= state_nxt;
      reach_r     <= reach_nxt;
      neg_r       <= neg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  // loop counters and datapath registers carry no reset
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    k_r        <= k_nxt;
    dik_r      <= dik_nxt;
    em_row_r   <= em_row_nxt;
    em_col_r   <= em_col_nxt;
    em_reach_r <= em_reach_nxt;
    em_last_r  <= em_last_nxt;
    em_neg_r   <= em_neg_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    dik_nxt       = dik_r;
    reach_nxt     = reach_r;
    neg_nxt       = neg_r;
    out_valid_nxt = 1'b0;
    em_row_nxt    = em_row_r;
    em_col_nxt    = em_col_r;
    em_reach_nxt  = em_reach_r;
    em_last_nxt   = em_last_r;
    em_neg_nxt    = em_neg_r;
    wr            = '0;
    rd_a_addr     = a_ij;
    rd_b_addr     = a_ij;

    unique case (state_r)
      apsp_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_data.action == apsp_pkg::ACT_EDGE) begin
            // load one edge; drop it if either end is out of range
            if (edge_ok) begin
              wr.we   = 1'b1;
              wr.addr = {in_data.src, in_data.dst};
              wr.data = {{(apsp_pkg::DIST_W - apsp_pkg::W_W){in_data.weight[apsp_pkg::W_W-1]}},
                         in_data.weight};
              reach_nxt[{in_data.src, in_data.dst}] = 1'b1;
            end
          end else if (n_eff == '0) begin
            // empty graph: emit nothing, just clear
            reach_nxt = '0;
            neg_nxt   = 1'b0;
          end else begin
            i_nxt     = '0;
            state_nxt = apsp_pkg::ST_DIAG;
          end
        end
      end

      apsp_pkg::ST_DIAG: begin
        // zero the diagonal, one entry a cycle
        wr.we   = 1'b1;
        wr.addr = {i_r, i_r};
        wr.data = '0;
        reach_nxt[{i_r, i_r}] = 1'b1;
        if (i_end) begin
          i_nxt     = '0;
          k_nxt     = '0;
          state_nxt = apsp_pkg::ST_RD_IK;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      apsp_pkg::ST_RD_IK: begin
        rd_a_addr = a_ik;
        if (reach_r[a_ik]) begin
          state_nxt = apsp_pkg::ST_WAIT_IK;
        end else if (i_end) begin
          state_nxt = apsp_pkg::ST_RD_KK;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end

      apsp_pkg::ST_WAIT_IK: begin
        dik_nxt   = rd_a_data;
        j_nxt     = '0;
        state_nxt = apsp_pkg::ST_RD_J;
      end

      apsp_pkg::ST_RD_J: begin
        rd_a_addr = a_kj;
        rd_b_addr = a_ij;
        if (reach_r[a_kj]) begin
          state_nxt = apsp_pkg::ST_CMP;
        end else if (!j_end) begin
          j_nxt = j_r + 1'b1;
        end else if (i_end) begin
          state_nxt = apsp_pkg::ST_RD_KK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = apsp_pkg::ST_RD_IK;
        end
      end

      apsp_pkg::ST_CMP: begin
        // relax d[i][j] through k; write back the improved distance
        if (!reach_r[a_ij] || (sum < rd_b_data)) begin
          wr.we            = 1'b1;
          wr.addr          = a_ij;
          wr.data          = sum;
          reach_nxt[a_ij]  = 1'b1;
          // forward into the held d[i][k] when this entry is d[i][k]
          if (j_r == k_r) begin
            dik_nxt = sum;
          end
        end
        if (!j_end) begin
          j_nxt     = j_r + 1'b1;
          state_nxt = apsp_pkg::ST_RD_J;
        end else if (i_end) begin
          state_nxt = apsp_pkg::ST_RD_KK;
        end else begin
          i_nxt     = i_r + 1'b1;
          state_nxt = apsp_pkg::ST_RD_IK;
        end
      end

      apsp_pkg::ST_RD_KK: begin
        rd_a_addr = a_kk;
        state_nxt = apsp_pkg::ST_CHK_KK;
      end

      apsp_pkg::ST_CHK_KK: begin
        i_nxt = '0;
        j_nxt = '0;
        if (reach_r[a_kk] && rd_a_data[apsp_pkg::DIST_W-1]) begin
          // negative cycle through k: stop the passes
          neg_nxt   = 1'b1;
          state_nxt = apsp_pkg::ST_EMIT;
        end else if (k_end) begin
          state_nxt = apsp_pkg::ST_EMIT;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = apsp_pkg::ST_RD_IK;
        end
      end

      apsp_pkg::ST_EMIT: begin
        // issue one read a cycle; the result shows the cycle after
        rd_a_addr     = a_ij;
        out_valid_nxt = 1'b1;
        em_row_nxt    = i_r;
        em_col_nxt    = j_r;
        em_reach_nxt  = reach_r[a_ij];
        em_last_nxt   = i_end && j_end;
        em_neg_nxt    = neg_r;
        if (i_end && j_end) begin
          reach_nxt = '0;
          neg_nxt   = 1'b0;
          state_nxt = apsp_pkg::ST_IDLE;
        end else if (j_end) begin
          j_nxt = '0;
          i_nxt = i_r + 1'b1;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      default: begin
        state_nxt = apsp_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != apsp_pkg::ST_IDLE);
  assign cfg_ready = (state_r == apsp_pkg::ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    out_data.row            = em_row_r;
    out_data.col            = em_col_r;
    out_data.distance       = em_reach_r ? rd_a_data : '0;
    out_data.reachable      = em_reach_r;
    out_data.negative_cycle = em_neg_r;
    out_data.last           = em_last_r;
  end

endmodule

[sv/apsp_checker.sv]
// Port-level checker of the all pairs shortest path unit, bound to the top level
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_unit_assert.svh"
module apsp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input apsp_pkg::in_item_t          in_data,
  input logic                        out_valid,
  input apsp_pkg::out_item_t         out_data,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [apsp_pkg::VCNT_W-1:0] cfg_data
);

  logic edge_acc;
  logic cfg_acc;
  assign edge_acc = start && !busy && (in_data.action == apsp_pkg::ACT_EDGE);
  assign cfg_acc  = cfg_valid && cfg_ready;

  `APSP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !busy && !out_valid, "not idle after reset")
  `APSP_ASSERT_CLK(a_edge_idle, edge_acc |=> !busy, "edge transaction raised busy")
  `APSP_ASSERT_CLK(a_emit_burst, out_valid && !out_data.last |=> out_valid, "gap in matrix")
  `APSP_ASSERT_CLK(a_after_last, out_valid && out_data.last |=> !out_valid, "result after last")
  `APSP_ASSERT_CLK(a_cfg_idle, cfg_acc |-> !busy && !out_valid && !$isunknown(cfg_data), "bad cfg")

endmodule

bind all_pairs_shortest_path_unit apsp_checker u_apsp_checker (.*);
